// ===== rtl/lfid_pkg.sv =====
package lfid_pkg;

	localparam int CMD_W    = 1;
	localparam int RID_W    = 12;
	localparam int GRANT_W  = 11;
	localparam int STATUS_W = 2;

	localparam int DEF_NUM_IDS       = 2048;
	localparam int DEF_MAP_WORD_BITS = 64;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;

endpackage

// ===== rtl/lowest_free_id_allocator_top.sv =====
// Lowest-free identifier allocator: one used bit per identifier, kept in a
// single-port-read map memory of MAP_WORD_BITS-wide words.
// Command channel (cmd_valid/cmd_ready): command 0 allocates the lowest free
// identifier, command 1 frees release_id. Response channel
// (rsp_valid/rsp_ready): one beat per command with granted_id and status
// (0 ok, 1 map full, 2 released identifier out of range).
// Operation: the controller handles one command at a time. An allocate
// reads map words upward from word 0 until one holds a free identifier
// or the last word is scanned. The scan streams one map word read per
// cycle through the memory's read port. A release reads and rewrites the
// one map word that holds release_id; an out of range release does not
// touch the map.
// Reset: the map memory is zeroed by a clearing pass of one word per cycle
// (32 words by default); cmd_ready stays low until it is done.
// Stall: the response sits in an output register; the next command is
// accepted while it waits, and its result is held back until the
// register drains.
module lowest_free_id_allocator_top #(
	parameter int NUM_IDS       = lfid_pkg::DEF_NUM_IDS,
	parameter int MAP_WORD_BITS = lfid_pkg::DEF_MAP_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [lfid_pkg::CMD_W-1:0]    command,
	input  logic [lfid_pkg::RID_W-1:0]    release_id,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [lfid_pkg::GRANT_W-1:0]  granted_id,
	output logic [lfid_pkg::STATUS_W-1:0] status
);

	localparam int MAP_WORDS = (NUM_IDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	logic                     ram_we;
	logic [WAW-1:0]           ram_waddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata;
	logic                     ram_re;
	logic [WAW-1:0]           ram_raddr;
	logic [MAP_WORD_BITS-1:0] ram_rdata;

	lfid_ram #(
		.WIDTH (MAP_WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lfid_ctrl #(
		.NUM_IDS       (NUM_IDS),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.command    (command),
		.release_id (release_id),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.granted_id (granted_id),
		.status     (status),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

endmodule

// ===== rtl/lfid_ram.sv =====
module lfid_ram #(
	parameter  int WIDTH = 64,
	parameter  int DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lfid_find.sv =====
module lfid_find #(
	parameter  int WIDTH = 64,
	localparam int IW    = $clog2(WIDTH)
) (
	input  logic [WIDTH-1:0] word,
	output logic             found,
	output logic [IW-1:0]    idx
);

	logic [WIDTH-1:0] free;
	logic [WIDTH-1:0] lowest;

	assign free   = ~word;
	assign lowest = free & (~free + WIDTH'(1));
	assign found  = |free;

	always_comb begin
		idx = '0;
		for (int i = 0; i < WIDTH; i++) begin
			if (lowest[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

// ===== rtl/lfid_ctrl.sv =====
module lfid_ctrl #(
	parameter  int NUM_IDS       = lfid_pkg::DEF_NUM_IDS,
	parameter  int MAP_WORD_BITS = lfid_pkg::DEF_MAP_WORD_BITS,
	localparam int MAP_WORDS     = (NUM_IDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
	localparam int WAW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [lfid_pkg::CMD_W-1:0]    command,
	input  logic [lfid_pkg::RID_W-1:0]    release_id,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [lfid_pkg::GRANT_W-1:0]  granted_id,
	output logic [lfid_pkg::STATUS_W-1:0] status,
	output logic                          ram_we,
	output logic [WAW-1:0]                ram_waddr,
	output logic [MAP_WORD_BITS-1:0]      ram_wdata,
	output logic                          ram_re,
	output logic [WAW-1:0]                ram_raddr,
	input  logic [MAP_WORD_BITS-1:0]      ram_rdata
);

	localparam int RID_W     = lfid_pkg::RID_W;
	localparam int BIT_W     = $clog2(MAP_WORD_BITS);
	localparam int ID_W      = $clog2(MAP_WORDS * MAP_WORD_BITS);
	localparam int LAST_BITS = NUM_IDS - (MAP_WORDS - 1) * MAP_WORD_BITS;
	localparam int RECIP_SH  = 24;
	localparam int RECIP_W   = 25;
	localparam int PROD_W    = RID_W + RECIP_W;

	localparam logic [WAW-1:0]           LAST_WORD = WAW'(MAP_WORDS - 1);
	localparam logic [MAP_WORD_BITS-1:0] PAD_MASK  =
		~({MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LAST_BITS));
	localparam logic [MAP_WORD_BITS-1:0] ONE       = MAP_WORD_BITS'(1);
	localparam logic [ID_W-1:0]          WORD_STEP = ID_W'(MAP_WORD_BITS);
	localparam logic [RECIP_W-1:0]       RECIP     =
		RECIP_W'((2 ** RECIP_SH + MAP_WORD_BITS - 1) / MAP_WORD_BITS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [lfid_pkg::CMD_W-1:0]      cmd_q;
	logic [RID_W-1:0]                rid_q;
	logic [WAW-1:0]                  rd_addr_q;
	logic [ID_W-1:0]                 rd_base_q;
	logic                            issue_q;
	logic [BIT_W-1:0]                rel_bit_q;
	logic                            rd_pend_s1;
	logic [WAW-1:0]                  rd_word_s1;
	logic [ID_W-1:0]                 rd_base_s1;
	logic [lfid_pkg::GRANT_W-1:0]    res_granted_q;
	logic [lfid_pkg::STATUS_W-1:0]   res_status_q;
	logic                            rsp_valid_q;
	logic [lfid_pkg::GRANT_W-1:0]    granted_q;
	logic [lfid_pkg::STATUS_W-1:0]   status_q;

	logic [PROD_W-1:0]               rel_prod;
	logic [WAW-1:0]                  rel_quot;
	logic [RID_W-1:0]                rel_span;
	logic [RID_W-1:0]                rel_rem;
	logic                            rid_bad;
	logic                            rd_last_s1;
	logic [MAP_WORD_BITS-1:0]        masked;
	logic                            found;
	logic [BIT_W-1:0]                fidx;
	logic [lfid_pkg::GRANT_W-1:0]    alloc_id;

	assign rel_prod   = PROD_W'(release_id) * PROD_W'(RECIP);
	assign rel_quot   = rel_prod[RECIP_SH +: WAW];
	assign rel_span   = RID_W'(rd_addr_q) * RID_W'(MAP_WORD_BITS);
	assign rel_rem    = rid_q - rel_span;
	assign rid_bad    = 32'(release_id) >= NUM_IDS;
	assign rd_last_s1 = rd_word_s1 == LAST_WORD;
	assign masked     = ram_rdata | (rd_last_s1 ? PAD_MASK : '0);
	assign alloc_id   = lfid_pkg::GRANT_W'(rd_base_s1 + ID_W'(fidx));

	lfid_find #(
		.WIDTH (MAP_WORD_BITS)
	) u_find (
		.word  (masked),
		.found (found),
		.idx   (fidx)
	);

	assign cmd_ready  = state_q == S_IDLE;
	assign rsp_valid  = rsp_valid_q;
	assign granted_id = granted_q;
	assign status     = status_q;

	assign ram_re    = (state_q == S_RUN) && issue_q;
	assign ram_raddr = rd_addr_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_word_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_q;
			ram_wdata = '0;
		end else if (state_q == S_RUN && rd_pend_s1) begin
			if (cmd_q == lfid_pkg::CMD_RELEASE) begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~(ONE << rel_bit_q);
			end else if (found) begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata | (ONE << fidx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cmd_q       <= lfid_pkg::CMD_ALLOC;
			rd_addr_q   <= '0;
			issue_q     <= 1'b0;
			rd_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= ram_re;
			if (ram_re) begin
				rd_addr_q  <= rd_addr_q + 1'b1;
				rd_base_q  <= rd_base_q + WORD_STEP;
				issue_q    <= (cmd_q == lfid_pkg::CMD_ALLOC) && (rd_addr_q != LAST_WORD);
				rd_word_s1 <= rd_addr_q;
				rd_base_s1 <= rd_base_q;
				rel_bit_q  <= rel_rem[BIT_W-1:0];
			end
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					rd_addr_q <= (rd_addr_q == LAST_WORD) ? '0 : rd_addr_q + 1'b1;
					if (rd_addr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q     <= command;
						rid_q     <= release_id;
						rd_base_q <= '0;
						issue_q   <= 1'b1;
						rd_addr_q <= (command == lfid_pkg::CMD_ALLOC) ? '0 : rel_quot;
						if (command == lfid_pkg::CMD_RELEASE && rid_bad) begin
							res_granted_q <= '0;
							res_status_q  <= lfid_pkg::ST_BAD_ID;
							state_q       <= S_DONE;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (rd_pend_s1) begin
						if (cmd_q == lfid_pkg::CMD_RELEASE) begin
							res_granted_q <= '0;
							res_status_q  <= lfid_pkg::ST_OK;
							state_q       <= S_DONE;
						end else if (found) begin
							res_granted_q <= alloc_id;
							res_status_q  <= lfid_pkg::ST_OK;
							state_q       <= S_DONE;
						end else if (rd_last_s1) begin
							res_granted_q <= '0;
							res_status_q  <= lfid_pkg::ST_FULL;
							state_q       <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						granted_q   <= res_granted_q;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("map word written and read in the same cycle");

	a_no_stale_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !rd_pend_s1)
		else $error("read data still in flight while idle");

	a_fail_grants_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != lfid_pkg::ST_OK |-> granted_q == '0)
		else $error("failed beat carries a nonzero identifier");

	a_bad_id_fast: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && command == lfid_pkg::CMD_RELEASE && rid_bad
		|=> state_q == S_DONE && res_status_q == lfid_pkg::ST_BAD_ID)
		else $error("out of range release did not bypass the map");

endmodule
